FILE: hdl/lru_stack_distance_profiler_defines.svh
// ----------------------------------------------------------------------------
// LRU stack distance profiler - assertion macros
// Shared concurrent assertion forms, clocked on clk, idle in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_STACK_DISTANCE_PROFILER_DEFINES_SVH
`define LRU_STACK_DISTANCE_PROFILER_DEFINES_SVH

// same-cycle implication
`define LSDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsdp assertion failed");

// next-cycle implication
`define LSDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsdp assertion failed");

`endif

FILE: hdl/lsdp_pkg.sv
// ----------------------------------------------------------------------------
// lsdp_pkg
// Shared constants, beat layout and types of the LRU stack distance profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdp_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int ADDR_BITS_DEF   = 48;
  localparam int HIST_BINS_DEF   = 8;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int OP_W        = 2;
  localparam int ADDR_W      = 48;
  localparam int SEL_W       = 3;
  localparam int IN_TDATA_W  = 56;

  localparam int OUT_DIST_W  = 7;
  localparam int OUT_BIN_W   = 3;
  localparam int OUT_CNT_W   = 32;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic access;
    logic clear;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/lsdp_cell.sv
// ----------------------------------------------------------------------------
// lsdp_cell
// One slot of the move-to-front stack: compares, then takes its upper
// neighbor's entry while no hit was found above it.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdp_cell import lsdp_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cell_ctl_t            ctl,
  input  wire logic [ADDR_BITS-1:0] search_addr,
  input  wire logic [ADDR_BITS-1:0] prev_addr,
  input  wire logic                 prev_valid,
  input  wire logic                 hit_in,
  output logic      [ADDR_BITS-1:0] addr_q,
  output logic                      valid_q,
  output logic                      match,
  output logic                      hit_out
);

  logic [ADDR_BITS-1:0] addr_r;
  logic                 valid_r;

  assign match   = valid_r && (addr_r == search_addr);
  assign hit_out = hit_in || match;
  assign addr_q  = addr_r;
  assign valid_q = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.access && !hit_in) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.access && !hit_in) begin
      addr_r <= prev_addr;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lsdp_stack.sv
// ----------------------------------------------------------------------------
// lsdp_stack
// Row of stack cells with the hit chain and the hit position encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdp_stack import lsdp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  localparam int POS_W      = $clog2(STACK_DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cell_ctl_t            ctl,
  input  wire logic [ADDR_BITS-1:0] search_addr,
  output logic      [POS_W-1:0]     hit_pos,
  output logic                      hit
);

  logic [ADDR_BITS-1:0] addr_q [STACK_DEPTH];
  logic                 valid_q [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] match;
  logic [STACK_DEPTH:0]   hit_c;

  assign hit_c[0] = 1'b0;
  assign hit      = hit_c[STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      lsdp_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .search_addr (search_addr),
        .prev_addr   (search_addr),
        .prev_valid  (1'b1),
        .hit_in      (hit_c[i]),
        .addr_q      (addr_q[i]),
        .valid_q     (valid_q[i]),
        .match       (match[i]),
        .hit_out     (hit_c[i+1])
      );
    end else begin : g_body
      lsdp_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .search_addr (search_addr),
        .prev_addr   (addr_q[i-1]),
        .prev_valid  (valid_q[i-1]),
        .hit_in      (hit_c[i]),
        .addr_q      (addr_q[i]),
        .valid_q     (valid_q[i]),
        .match       (match[i]),
        .hit_out     (hit_c[i+1])
      );
    end
  end

  // entries are distinct, so at most one match: OR the indices
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (match[i]) begin
        hit_pos = hit_pos | POS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lru_stack_distance_profiler.sv
// The stack search and move-to-front run in the accept cycle, which also
// registers the beat's op, select and hit position and moves the FSM to
// ST_HIST; the histogram read-modify-write follows in the next. A new beat
// is taken only in ST_IDLE, once the output register is free or being drained.
// Reset (rst_n low, synchronous) empties the stack and zeroes the histogram
// and the sample total at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// lru_stack_distance_profiler
// LRU stack distance per address, binned log2p1 into a saturating histogram.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_stack_distance_profiler_defines.svh"

module lru_stack_distance_profiler import lsdp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  parameter int HIST_BINS   = HIST_BINS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // addr[47:0], bin_select[50:48]
  input  wire logic [OP_W-1:0]        in_tuser,   // op[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // stack_distance[6:0], dist_bin[9:7],
                                                  // bin_count[41:10], sample_total[73:42]
);

  localparam int POS_W  = $clog2(STACK_DEPTH);
  localparam int DIST_W = $clog2(STACK_DEPTH + 1);
  localparam int LB_W   = $clog2(DIST_W + 1);
  localparam int BIN_W  = $clog2(HIST_BINS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HIST = 2'b10
  } state_t;

  state_t                st_r, st_nxt;
  logic                  in_fire;
  op_t                   op_in;
  cell_ctl_t             cell_ctl;
  logic [ADDR_BITS-1:0]  search_addr;
  logic [POS_W-1:0]      hit_pos;
  logic                  hit;

  op_t                   op_r;
  logic [SEL_W-1:0]      sel_r;
  logic [POS_W-1:0]      pos_r;
  logic                  hit_r;

  logic [COUNT_BITS-1:0] hist_r [HIST_BINS];
  logic [COUNT_BITS-1:0] hist_nxt [HIST_BINS];
  logic [COUNT_BITS-1:0] sample_r, sample_nxt;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [DIST_W-1:0]     dist_val;
  logic [LB_W-1:0]       lb;
  logic [BIN_W-1:0]      bin;
  logic                  sel_ok;
  logic [BIN_W-1:0]      idx;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;

  assign in_fire     = in_tvalid && in_tready;
  assign in_tready   = (st_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign op_in       = op_t'(in_tuser);
  assign search_addr = ADDR_BITS'(in_tdata[ADDR_W-1:0]);
  assign cell_ctl.access = in_fire && (op_in == OP_ACCESS);
  assign cell_ctl.clear  = in_fire && (op_in == OP_CLEAR);

  lsdp_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_stack (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (cell_ctl),
    .search_addr (search_addr),
    .hit_pos     (hit_pos),
    .hit         (hit)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_in;
      sel_r <= in_tdata[ADDR_W +: SEL_W];
      pos_r <= hit_pos;
      hit_r <= hit;
    end
  end

  always_comb begin
    dist_val = hit_r ? DIST_W'(pos_r) : DIST_W'(STACK_DEPTH);
    lb       = '0;
    for (int i = 0; i < DIST_W; i++) begin
      if (dist_val[i]) begin
        lb = LB_W'(i + 1);
      end
    end
    if (32'(lb) >= 32'(HIST_BINS)) begin
      bin = BIN_W'(HIST_BINS - 1);
    end else begin
      bin = BIN_W'(lb);
    end
    sel_ok  = 32'(sel_r) < 32'(HIST_BINS);
    idx     = (op_r == OP_READ) ? BIN_W'(sel_r) : bin;
    rd_cnt  = hist_r[idx];
    inc_cnt = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
  end

  always_comb begin
    st_nxt       = st_r;
    hist_nxt     = hist_r;
    sample_nxt   = sample_r;
    out_data_nxt = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          st_nxt = ST_HIST;
        end
      end
      ST_HIST: begin
        st_nxt = ST_IDLE;
        case (op_r)
          OP_ACCESS: begin
            hist_nxt[bin] = inc_cnt;
            sample_nxt    = (sample_r == COUNT_MAX) ? sample_r : sample_r + 1'b1;
            out_data_nxt[0 +: OUT_DIST_W]                      = OUT_DIST_W'(dist_val);
            out_data_nxt[OUT_DIST_W +: OUT_BIN_W]              = OUT_BIN_W'(bin);
            out_data_nxt[OUT_DIST_W + OUT_BIN_W +: OUT_CNT_W]  = OUT_CNT_W'(inc_cnt);
          end
          OP_READ: begin
            if (sel_ok) begin
              out_data_nxt[OUT_DIST_W + OUT_BIN_W +: OUT_CNT_W] = OUT_CNT_W'(rd_cnt);
            end
          end
          OP_CLEAR: begin
            for (int i = 0; i < HIST_BINS; i++) begin
              hist_nxt[i] = '0;
            end
            sample_nxt = '0;
          end
          default: begin
          end
        endcase
        out_data_nxt[OUT_DIST_W + OUT_BIN_W + OUT_CNT_W +: OUT_CNT_W] =
          OUT_CNT_W'(sample_nxt);
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sample_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_BINS; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      sample_r <= sample_nxt;
      hist_r   <= hist_nxt;
      if (st_r == ST_HIST) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_HIST) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LSDP_ASSERT_NEXT(a_accept_to_hist, in_fire, st_r == ST_HIST)
  `LSDP_ASSERT_NOW(a_hist_slot_free, st_r == ST_HIST, !out_valid_r)
  `LSDP_ASSERT_NEXT(a_clear_zeroes, (st_r == ST_HIST) && (op_r == OP_CLEAR),
    (sample_r == '0) && out_valid_r)

endmodule

`default_nettype wire
